// ===== design/rwp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; every other design file uses this package.
package rwp_pkg;

  // Default width of the byte position counter.
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // Chunk and file tags as read little-endian from four bytes.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE = 32'd44;
  localparam logic [31:0] MIN_FMT  = 32'd16;
  localparam logic [15:0] FMT_PCM  = 16'd1;

  // Offsets of the captured fields inside the fmt chunk body.
  localparam logic [4:0] FB_FORMAT_LO = 5'd0;
  localparam logic [4:0] FB_FORMAT_HI = 5'd1;
  localparam logic [4:0] FB_CHAN_LO   = 5'd2;
  localparam logic [4:0] FB_CHAN_HI   = 5'd3;
  localparam logic [4:0] FB_RATE_0    = 5'd4;
  localparam logic [4:0] FB_RATE_1    = 5'd5;
  localparam logic [4:0] FB_RATE_2    = 5'd6;
  localparam logic [4:0] FB_RATE_3    = 5'd7;
  localparam logic [4:0] FB_BITS_LO   = 5'd14;
  localparam logic [4:0] FB_BITS_HI   = 5'd15;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
    logic [31:0] rate_hz;
    logic [4:0]  sample_bits;
    logic [1:0]  channel_count;
    logic        parse_ok;
  } result_t;

endpackage

// ===== design/rwp_in_reg.sv =====
// Input register stage of the RIFF/WAVE header parser.
// Depends on rwp_pkg for the item type.
module rwp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rwp_pkg::item_t in_item,
  output logic           item_valid,
  output rwp_pkg::item_t item,
  input  logic           item_take
);

  logic           valid_r;
  rwp_pkg::item_t item_r;

  // The stage refills in the same cycle that the parser drains it.
  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== design/rwp_core.sv =====
// Parsing state and the one-byte update of the RIFF/WAVE header parser.
// Depends on rwp_pkg for tags, limits and the item and result types.
module rwp_core #(
  parameter int unsigned OFFSET_BITS = rwp_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  rwp_pkg::item_t   item,
  output logic             item_take,
  input  logic             slot_free,
  output logic             res_valid,
  output rwp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHDR, PH_BODY, PH_PAD, PH_DONE
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [2:0]             fidx_r, fidx_nxt;
  logic [31:0]            tag_r, tag_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [31:0]            remain_r, remain_nxt;
  logic [4:0]             bidx_r, bidx_nxt;
  logic                   is_fmt_r, is_fmt_nxt;
  logic                   pad_r, pad_nxt;
  logic [15:0]            format_r, format_nxt;
  logic [15:0]            chan_r, chan_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [15:0]            bits_r, bits_nxt;
  logic                   fmt_found_r, fmt_found_nxt;
  logic                   data_found_r, data_found_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [31:0]            len_r, len_nxt;
  logic                   err_r, err_nxt;
  logic                   ok;
  logic [7:0]             b;

  function automatic phase_t chunk_end(input logic fmt_f, input logic data_f,
                                       input logic pad);
    phase_t p;
    if (fmt_f && data_f) begin
      p = PH_DONE;
    end else if (pad) begin
      p = PH_PAD;
    end else begin
      p = PH_CHDR;
    end
    return p;
  endfunction

  // Only the final byte of a file needs a free result slot.
  assign item_take = item_valid && (!item.last_byte || slot_free);
  assign b         = item.data_byte;

  always_comb begin
    phase_nxt      = phase_r;
    fidx_nxt       = fidx_r;
    tag_nxt        = tag_r;
    size_nxt       = size_r;
    remain_nxt     = remain_r;
    bidx_nxt       = bidx_r;
    is_fmt_nxt     = is_fmt_r;
    pad_nxt        = pad_r;
    format_nxt     = format_r;
    chan_nxt       = chan_r;
    rate_nxt       = rate_r;
    bits_nxt       = bits_r;
    fmt_found_nxt  = fmt_found_r;
    data_found_nxt = data_found_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    err_nxt        = err_r;

    if (pos_r == POS_MAX) begin
      err_nxt = 1'b1;
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end

    if (!err_nxt) begin
      case (phase_r)
        PH_RIFF, PH_WAVE: begin
          tag_nxt = {b, tag_r[31:8]};
          if (fidx_r >= 3'd3) begin
            fidx_nxt = '0;
            if (tag_nxt != ((phase_r == PH_RIFF) ? rwp_pkg::TAG_RIFF
                                                 : rwp_pkg::TAG_WAVE)) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt = (phase_r == PH_RIFF) ? PH_RSIZE : PH_CHDR;
            end
          end else begin
            fidx_nxt = fidx_r + 3'd1;
          end
        end
        PH_RSIZE: begin
          if (fidx_r >= 3'd3) begin
            fidx_nxt  = '0;
            phase_nxt = PH_WAVE;
          end else begin
            fidx_nxt = fidx_r + 3'd1;
          end
        end
        PH_CHDR: begin
          if (fidx_r < 3'd4) begin
            tag_nxt = {b, tag_r[31:8]};
          end else begin
            size_nxt = {b, size_r[31:8]};
          end
          if (fidx_r == 3'd7) begin
            fidx_nxt   = '0;
            is_fmt_nxt = (tag_nxt == rwp_pkg::TAG_FMT);
            if (is_fmt_nxt && size_nxt < rwp_pkg::MIN_FMT) begin
              err_nxt = 1'b1;
            end else begin
              if (is_fmt_nxt) begin
                fmt_found_nxt = 1'b1;
              end else if (tag_nxt == rwp_pkg::TAG_DATA) begin
                data_found_nxt = 1'b1;
                start_nxt      = pos_nxt;
                len_nxt        = size_nxt;
              end
              remain_nxt = size_nxt;
              bidx_nxt   = '0;
              pad_nxt    = size_nxt[0];
              if (size_nxt == '0) begin
                phase_nxt = chunk_end(fmt_found_nxt, data_found_nxt, pad_nxt);
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end else begin
            fidx_nxt = fidx_r + 3'd1;
          end
        end
        PH_BODY: begin
          if (is_fmt_r) begin
            case (bidx_r)
              rwp_pkg::FB_FORMAT_LO: format_nxt[7:0]   = b;
              rwp_pkg::FB_FORMAT_HI: format_nxt[15:8]  = b;
              rwp_pkg::FB_CHAN_LO:   chan_nxt[7:0]     = b;
              rwp_pkg::FB_CHAN_HI:   chan_nxt[15:8]    = b;
              rwp_pkg::FB_RATE_0:    rate_nxt[7:0]     = b;
              rwp_pkg::FB_RATE_1:    rate_nxt[15:8]    = b;
              rwp_pkg::FB_RATE_2:    rate_nxt[23:16]   = b;
              rwp_pkg::FB_RATE_3:    rate_nxt[31:24]   = b;
              rwp_pkg::FB_BITS_LO:   bits_nxt[7:0]     = b;
              rwp_pkg::FB_BITS_HI:   bits_nxt[15:8]    = b;
              default: ;
            endcase
          end
          if (bidx_r < rwp_pkg::MIN_FMT[4:0]) begin
            bidx_nxt = bidx_r + 5'd1;
          end
          remain_nxt = remain_r - 32'd1;
          if (remain_nxt == '0) begin
            phase_nxt = chunk_end(fmt_found_r, data_found_r, pad_r);
          end
        end
        PH_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_CHDR;
        end
        default: ;
      endcase
    end

    ok = !err_nxt
      && pos_nxt >= OFFSET_BITS'(rwp_pkg::MIN_FILE)
      && phase_nxt != PH_BODY
      && fmt_found_nxt && data_found_nxt
      && len_nxt != '0
      && format_nxt == rwp_pkg::FMT_PCM
      && (bits_nxt == 16'd8 || bits_nxt == 16'd16)
      && (chan_nxt == 16'd1 || chan_nxt == 16'd2);

    if (ok) begin
      res.parse_ok       = 1'b1;
      res.channel_count  = chan_nxt[1:0];
      res.sample_bits    = bits_nxt[4:0];
      res.rate_hz        = rate_nxt;
      res.payload_offset = 32'(start_nxt);
      res.payload_size   = len_nxt;
    end else begin
      res = '0;
    end
  end

  assign res_valid = item_take && item.last_byte;

  always_ff @(posedge clk) begin
    // The final byte of a file returns the parser to its starting state.
    if (!rst_n || res_valid) begin
      phase_r      <= PH_RIFF;
      pos_r        <= '0;
      fidx_r       <= '0;
      tag_r        <= '0;
      size_r       <= '0;
      remain_r     <= '0;
      bidx_r       <= '0;
      is_fmt_r     <= 1'b0;
      pad_r        <= 1'b0;
      format_r     <= '0;
      chan_r       <= '0;
      rate_r       <= '0;
      bits_r       <= '0;
      fmt_found_r  <= 1'b0;
      data_found_r <= 1'b0;
      start_r      <= '0;
      len_r        <= '0;
      err_r        <= 1'b0;
    end else if (item_take) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      fidx_r       <= fidx_nxt;
      tag_r        <= tag_nxt;
      size_r       <= size_nxt;
      remain_r     <= remain_nxt;
      bidx_r       <= bidx_nxt;
      is_fmt_r     <= is_fmt_nxt;
      pad_r        <= pad_nxt;
      format_r     <= format_nxt;
      chan_r       <= chan_nxt;
      rate_r       <= rate_nxt;
      bits_r       <= bits_nxt;
      fmt_found_r  <= fmt_found_nxt;
      data_found_r <= data_found_nxt;
      start_r      <= start_nxt;
      len_r        <= len_nxt;
      err_r        <= err_nxt;
    end
  end

  a_bidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r <= rwp_pkg::MIN_FMT[4:0])
    else $error("fmt body index ran past its limit");

  a_tag_fidx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RIFF || phase_r == PH_RSIZE || phase_r == PH_WAVE) |-> fidx_r <= 3'd3)
    else $error("field index out of range in a file tag phase");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_RIFF && pos_r == '0 && !err_r))
    else $error("parser did not restart after the final byte");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.parse_ok) |-> (res.rate_hz == '0 && res.payload_size == '0))
    else $error("error result carries nonzero fields");

  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> remain_r != '0)
    else $error("body phase with nothing left to consume");

endmodule

// ===== design/rwp_out_reg.sv =====
// Result register of the RIFF/WAVE header parser.
// Depends on rwp_pkg for the result type.
module rwp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  rwp_pkg::result_t res,
  output logic             slot_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output rwp_pkg::result_t out_res
);

  logic             valid_r;
  rwp_pkg::result_t res_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/riff_wave_header_parser.sv =====
// RIFF/WAVE header parser: takes a WAV file one byte per cycle on the input stream, with
// in_tlast on the final byte, and gives one result request per file. Every byte is taken
// back to back, including while a result waits at the output; the final byte of a file
// waits only if the previous result has not yet been taken. The final byte is accepted
// into the input register and held there until the parser's state update takes it and
// writes the result to the output register, which presents the result request. After
// the result the parser is back at its starting state, ready for the next file.
// Depends on rwp_pkg, rwp_in_reg, rwp_core and rwp_out_reg.
module riff_wave_header_parser #(
  parameter int unsigned OFFSET_BITS = rwp_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] parse_ok, [2:1] channel_count, [7:3] sample_bits, [39:8] rate_hz,
  // [71:40] payload_offset, [103:72] payload_size
  output logic [103:0] out_tdata
);

  rwp_pkg::item_t   in_item;
  rwp_pkg::item_t   item;
  rwp_pkg::result_t res;
  rwp_pkg::result_t out_res;
  logic             item_valid;
  logic             item_take;
  logic             slot_free;
  logic             res_valid;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;
  assign out_tdata         = out_res;

  rwp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rwp_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  rwp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

endmodule
